@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and helpers for the fixed-point ALU
// Opcodes, the per-stage side payload and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int FracBitsDef = 8;
  localparam int WordW       = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_t;

  // payload that rides alongside the divider chain
  typedef struct packed {
    logic [3:0]  op;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] res;   // result of the non-multiply ops (also the divide-by-zero result)
    logic [63:0] prod;  // |a| * |b|
    logic        neg;   // sign of product or quotient
    logic        bz;    // divisor is zero
  } side_t;

  // {ovf, value}: clamp a sign and magnitude into the signed 32-bit range
  function automatic logic [32:0] sat32(input logic neg, input logic [64:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (mag > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                       r = {1'b0, mag[31:0]};
    end else begin
      if (mag > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else                       r = {1'b0, 32'h0 - mag[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fpa_div_cell.sv @@
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division step
// Brings down one dividend bit, trial-subtracts the divisor, registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div_cell import fpa_pkg::*; #(
  parameter int DW = 41
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [31:0]   den_i,
  input  wire logic [31:0]   rem_i,
  input  wire logic [DW-1:0] dvd_i,
  input  wire logic [DW-1:0] quo_i,
  output logic      [31:0]   den_o,
  output logic      [31:0]   rem_o,
  output logic      [DW-1:0] dvd_o,
  output logic      [DW-1:0] quo_o
);

  logic [32:0]   trial;
  logic [32:0]   diff;
  logic          ge;
  logic [31:0]   rem_nxt;

  always_comb begin
    trial   = {rem_i, dvd_i[DW-1]};
    diff    = trial - {1'b0, den_i};
    ge      = (trial >= {1'b0, den_i});
    rem_nxt = ge ? diff[31:0] : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_o <= den_i;
      rem_o <= rem_nxt;
      dvd_o <= {dvd_i[DW-2:0], 1'b0};
      quo_o <= {quo_i[DW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ rtl/fpa_prep.sv @@
// ----------------------------------------------------------------------------
// fpa_prep: front-end decode
// Compare flags, direct op results, magnitude product and divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_prep import fpa_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int DW        = 33 + FRAC_BITS
) (
  input  wire logic [3:0]    op_i,
  input  wire logic [31:0]   a_i,
  input  wire logic [31:0]   b_i,
  output side_t              side_o,
  output logic      [DW-1:0] dvd_o,
  output logic      [31:0]   den_o
);

  logic        an, bn;
  logic [31:0] amag, bmag;
  logic        gt, lt;

  always_comb begin
    an   = a_i[31];
    bn   = b_i[31];
    amag = an ? (32'h0 - a_i) : a_i;
    bmag = bn ? (32'h0 - b_i) : b_i;
    gt   = ($signed(a_i) > $signed(b_i));
    lt   = ($signed(a_i) < $signed(b_i));

    side_o.op   = op_i;
    side_o.gt   = gt;
    side_o.lt   = lt;
    side_o.eq   = (a_i == b_i);
    side_o.prod = {32'h0, amag} * {32'h0, bmag};
    side_o.neg  = an ^ bn;
    side_o.bz   = (b_i == 32'h0);

    case (op_t'(op_i))
      OP_ADD:      side_o.res = a_i + b_i;
      OP_SUB:      side_o.res = a_i - b_i;
      OP_MIN:      side_o.res = lt ? a_i : b_i;
      OP_MAX:      side_o.res = gt ? a_i : b_i;
      OP_INC:      side_o.res = a_i + 32'h1;
      OP_DEC:      side_o.res = a_i - 32'h1;
      OP_TO_INT:   side_o.res = 32'($signed(a_i) >>> FRAC_BITS);
      OP_FROM_INT: side_o.res = a_i << FRAC_BITS;
      OP_DIV:      side_o.res = an ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:     side_o.res = 32'h0;
    endcase

    // 2*|a|*2^F so the chain yields one extra quotient bit for rounding
    dvd_o = {amag, {FRAC_BITS{1'b0}}, 1'b0};
    den_o = bmag;
  end

endmodule

`default_nettype wire

@@ rtl/fixed_point_alu_core.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_core: signed Q(31-F).F arithmetic unit
// Pipelined add/sub/mul/div/min/max/inc/dec/shift with exact rounded divide.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A new beat is taken every cycle while the
// output side keeps up; every beat passes the input decode and product
// register, then each cell of the FRAC_BITS + 33 cell restoring divider
// chain, then the rounding and output register. All opcodes travel the
// same path so results leave in order. The whole pipe stalls only while a
// result sits unread.
`default_nettype none

module fixed_point_alu_core import fpa_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_req_type,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_result_value,
  output logic             out_a_greater,
  output logic             out_a_less,
  output logic             out_a_equal,
  output logic             out_overflowed,
  output logic             out_divided_by_zero
);

  localparam int QW = 33 + FRAC_BITS;  // quotient bits = chain length

  logic adv;  // pipe advance

  // stage arrays: index k feeds cell k, index k+1 is its output
  logic  [QW:0]         v_r;
  side_t                side_r [QW+1];
  logic  [31:0]         den_s  [QW+1];
  logic  [31:0]         rem_s  [QW+1];
  logic  [QW-1:0]       dvd_s  [QW+1];
  logic  [QW-1:0]       quo_s  [QW+1];

  side_t                prep_side;
  logic  [QW-1:0]       prep_dvd;
  logic  [31:0]         prep_den;

  logic                 out_valid_r;
  logic [31:0]          res_r;
  logic                 gt_r, lt_r, eq_r, ovf_r, dz_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  fpa_prep #(.FRAC_BITS(FRAC_BITS), .DW(QW)) u_prep (
    .op_i   (in_req_type),
    .a_i    (in_operand_a),
    .b_i    (in_operand_b),
    .side_o (prep_side),
    .dvd_o  (prep_dvd),
    .den_o  (prep_den)
  );

  // stage 0: decode and product register
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= prep_side;
      den_s[0]  <= prep_den;
      rem_s[0]  <= 32'h0;
      dvd_s[0]  <= prep_dvd;
      quo_s[0]  <= '0;
    end
  end

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_chain
      fpa_div_cell #(.DW(QW)) u_cell (
        .clk   (clk),
        .en    (adv),
        .den_i (den_s[k]),
        .rem_i (rem_s[k]),
        .dvd_i (dvd_s[k]),
        .quo_i (quo_s[k]),
        .den_o (den_s[k+1]),
        .rem_o (rem_s[k+1]),
        .dvd_o (dvd_s[k+1]),
        .quo_o (quo_s[k+1])
      );

      always_ff @(posedge clk) begin
        if (adv) side_r[k+1] <= side_r[k];
      end
    end
  endgenerate

  // valid bits march with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QW-1:0], in_valid};
    end
  end

  // finish: rounding and saturation of mul/div
  side_t        fin;
  logic [63:0]  mul_q;
  logic [QW:0]  div_q;
  logic [32:0]  sat_r;
  logic [31:0]  res_nxt;
  logic         ovf_nxt, dz_nxt;

  always_comb begin
    fin     = side_r[QW];
    mul_q   = (fin.prod + (64'h1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    // q = floor((2n/d + 1) / 2): ties away from zero
    div_q   = ({1'b0, quo_s[QW]} + {{QW{1'b0}}, 1'b1}) >> 1;
    sat_r   = 33'h0;
    res_nxt = fin.res;
    ovf_nxt = 1'b0;
    dz_nxt  = 1'b0;
    case (op_t'(fin.op))
      OP_MUL: begin
        sat_r   = sat32(fin.neg, {1'b0, mul_q});
        res_nxt = sat_r[31:0];
        ovf_nxt = sat_r[32];
      end
      OP_DIV: begin
        if (fin.bz) begin
          ovf_nxt = 1'b1;
          dz_nxt  = 1'b1;
        end else begin
          sat_r   = sat32(fin.neg, {{(64-QW){1'b0}}, div_q});
          res_nxt = sat_r[31:0];
          ovf_nxt = sat_r[32];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      gt_r  <= fin.gt;
      lt_r  <= fin.lt;
      eq_r  <= fin.eq;
      ovf_r <= ovf_nxt;
      dz_r  <= dz_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = res_r;
  assign out_a_greater       = gt_r;
  assign out_a_less          = lt_r;
  assign out_a_equal         = eq_r;
  assign out_overflowed      = ovf_r;
  assign out_divided_by_zero = dz_r;

  // divide by zero always reports saturation
  a_dz_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!dz_r || ovf_r))
    else $error("divide-by-zero without overflow");

  // compare flags are mutually exclusive
  a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones({gt_r, lt_r, eq_r}) == 1))
    else $error("compare flags not one-hot");

  // a stalled result keeps the pipe frozen
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(v_r)))
    else $error("pipe moved while stalled");

endmodule

`default_nettype wire
